// ----- rtl/fixed_chunk_pool_allocator_assert.svh -----
// Assertion macros used by the checker file.
`ifndef FIXED_CHUNK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_CHUNK_POOL_ALLOCATOR_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define FCPA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define FCPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fcpa_pkg.sv -----
package fcpa_pkg;

    localparam int POOL_DEPTH = 256;
    localparam int IDX_W      = 8;
    localparam int POOL_SPAN  = (POOL_DEPTH < (1 << IDX_W)) ? POOL_DEPTH : (1 << IDX_W);
    localparam int RAM_AW     = (POOL_SPAN > 1) ? $clog2(POOL_SPAN) : 1;
    localparam int CNT_W      = 9;
    localparam int BYTES_W    = 16;
    localparam int ADDR_W     = 32;
    localparam int PROD_W     = IDX_W + BYTES_W;
    localparam int PADDR_W    = 4;

    localparam logic [CNT_W-1:0] POOL_SPAN_CNT = CNT_W'(POOL_SPAN);
    localparam logic [CNT_W-1:0] COUNT_MAX     = '1;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_RESET = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_REFUSED = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [BYTES_W-1:0] request_bytes;
        logic [IDX_W-1:0]   chunk_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [IDX_W-1:0]  granted_index;
        logic [ADDR_W-1:0] granted_address;
        logic [CNT_W-1:0]  free_count;
    } out_item_t;

    typedef struct packed {
        logic [BYTES_W-1:0] chunk_bytes;
        logic [CNT_W-1:0]   chunks_in_use;
        logic [ADDR_W-1:0]  pool_base;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [IDX_W-1:0]  wdata;
    } ram_req_t;

endpackage

// ----- rtl/fcpa_regs.sv -----
module fcpa_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fcpa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output fcpa_pkg::cfg_t               cfg
);

    localparam logic [1:0] REG_CHUNK_BYTES = 2'd0;
    localparam logic [1:0] REG_CHUNKS      = 2'd1;
    localparam logic [1:0] REG_BASE        = 2'd2;

    fcpa_pkg::cfg_t cfg_reg, cfg_next;
    logic           wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[3:2])
                REG_CHUNK_BYTES: cfg_next.chunk_bytes   = pwdata[fcpa_pkg::BYTES_W-1:0];
                REG_CHUNKS:      cfg_next.chunks_in_use = pwdata[fcpa_pkg::CNT_W-1:0];
                REG_BASE:        cfg_next.pool_base     = pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CHUNK_BYTES: prdata = 32'(cfg_reg.chunk_bytes);
            REG_CHUNKS:      prdata = 32'(cfg_reg.chunks_in_use);
            REG_BASE:        prdata = cfg_reg.pool_base;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.chunk_bytes   <= 16'd8;
            cfg_reg.chunks_in_use <= '0;
            cfg_reg.pool_base     <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/fcpa_link_ram.sv -----
module fcpa_link_ram (
    input  logic                           aclk,
    input  fcpa_pkg::ram_req_t             req,
    output logic [fcpa_pkg::IDX_W-1:0]     rdata
);

    logic [fcpa_pkg::IDX_W-1:0] mem [fcpa_pkg::POOL_SPAN];
    logic [fcpa_pkg::IDX_W-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

endmodule

// ----- rtl/fcpa_ctrl.sv -----
module fcpa_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fcpa_pkg::cfg_t             cfg,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  fcpa_pkg::in_item_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output fcpa_pkg::out_item_t        m_data,
    output fcpa_pkg::ram_req_t         ram_req,
    input  logic [fcpa_pkg::IDX_W-1:0] ram_rdata
);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_ALLOC_RD = 4'b0010,
        ST_REBUILD  = 4'b0100,
        ST_EMIT     = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [fcpa_pkg::IDX_W-1:0]    head_reg, head_next;
    logic [fcpa_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [fcpa_pkg::CNT_W-1:0]    walk_reg, walk_next;
    logic [fcpa_pkg::CNT_W-1:0]    span_reg, span_next;
    logic [fcpa_pkg::PROD_W-1:0]   product_reg, product_next;
    logic [1:0]                    pend_status_reg, pend_status_next;
    logic [fcpa_pkg::IDX_W-1:0]    pend_index_reg, pend_index_next;
    logic [fcpa_pkg::ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                          m_valid_reg, m_valid_next;
    fcpa_pkg::out_item_t           m_data_reg, m_data_next;
    logic [fcpa_pkg::CNT_W-1:0]    pool_size;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign pool_size = (cfg.chunks_in_use > fcpa_pkg::POOL_SPAN_CNT) ?
                       fcpa_pkg::POOL_SPAN_CNT : cfg.chunks_in_use;

    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        walk_next        = walk_reg;
        span_next        = span_reg;
        product_next     = product_reg;
        pend_status_next = pend_status_reg;
        pend_index_next  = pend_index_reg;
        pend_addr_next   = pend_addr_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        ram_req.we       = 1'b0;
        ram_req.addr     = fcpa_pkg::RAM_AW'(head_reg);
        ram_req.wdata    = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pend_status_next = fcpa_pkg::STATUS_OK;
                    pend_index_next  = '0;
                    pend_addr_next   = '0;
                    state_next       = ST_EMIT;
                    unique case (s_data.kind)
                        fcpa_pkg::KIND_ALLOC: begin
                            if (s_data.request_bytes > cfg.chunk_bytes || count_reg == '0) begin
                                pend_status_next = fcpa_pkg::STATUS_REFUSED;
                            end else begin
                                // read the next link while the product settles
                                product_next    = fcpa_pkg::PROD_W'(head_reg) *
                                                  fcpa_pkg::PROD_W'(cfg.chunk_bytes);
                                pend_index_next = head_reg;
                                state_next      = ST_ALLOC_RD;
                            end
                        end
                        fcpa_pkg::KIND_FREE: begin
                            if (fcpa_pkg::CNT_W'(s_data.chunk_index) >= pool_size ||
                                count_reg == fcpa_pkg::COUNT_MAX) begin
                                pend_status_next = fcpa_pkg::STATUS_RANGE;
                            end else begin
                                ram_req.we    = 1'b1;
                                ram_req.addr  = fcpa_pkg::RAM_AW'(s_data.chunk_index);
                                ram_req.wdata = (count_reg != '0) ? head_reg : '0;
                                head_next     = s_data.chunk_index;
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        fcpa_pkg::KIND_RESET: begin
                            span_next = pool_size;
                            walk_next = '0;
                            if (pool_size == '0) begin
                                head_next  = '0;
                                count_next = '0;
                            end else begin
                                state_next = ST_REBUILD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ALLOC_RD: begin
                head_next      = ram_rdata;
                count_next     = count_reg - 1'b1;
                pend_addr_next = cfg.pool_base + fcpa_pkg::ADDR_W'(product_reg);
                state_next     = ST_EMIT;
            end
            ST_REBUILD: begin
                // each entry links to the one below it, entry zero ends the list
                ram_req.we    = 1'b1;
                ram_req.addr  = fcpa_pkg::RAM_AW'(walk_reg);
                ram_req.wdata = (walk_reg == '0) ? '0 : fcpa_pkg::IDX_W'(walk_reg - 1'b1);
                if (walk_reg == span_reg - 1'b1) begin
                    head_next  = fcpa_pkg::IDX_W'(walk_reg);
                    count_next = span_reg;
                    state_next = ST_EMIT;
                end else begin
                    walk_next = walk_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.status          = pend_status_reg;
                    m_data_next.granted_index   = pend_index_reg;
                    m_data_next.granted_address = pend_addr_reg;
                    m_data_next.free_count      = count_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg        <= walk_next;
        span_reg        <= span_next;
        product_reg     <= product_next;
        pend_status_reg <= pend_status_next;
        pend_index_reg  <= pend_index_next;
        pend_addr_reg   <= pend_addr_next;
        m_data_reg      <= m_data_next;
    end

endmodule

// ----- rtl/fixed_chunk_pool_allocator.sv -----
// Fixed-size chunk pool allocator with a LIFO free list kept in a link memory.
// Input channel s_valid/s_ready/s_data carries one item: allocate, free a chunk,
// or rebuild the pool. Each item yields exactly one result item on
// m_valid/m_ready/m_data: status, granted index and address, free count.
// Configuration (chunk size, chunk count, base address) goes through the APB
// port at byte addresses 0, 4 and 8; write it only while the block is idle.
// Path from accept to result valid: free and unused kinds go straight to the
// emit state; an allocate first reads the next link (it comes out of the
// synchronous link memory in the cycle after the read); a pool rebuild walks
// the pool first, the sequencer writing one link entry per cycle.
// One item is in flight at a time; s_ready rises again as soon as the result
// moves into the output register, so a new item may be taken while that
// result still waits for m_ready.
// A stalled receiver holds the result in the output register; a following
// item finishes its work and then waits until the register frees up.
// Reset (aresetn, synchronous) empties the list and restores chunk size 8,
// chunk count 0 and base 0; the link memory needs no clearing pass.
module fixed_chunk_pool_allocator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  fcpa_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output fcpa_pkg::out_item_t          m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fcpa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    fcpa_pkg::cfg_t             cfg;
    fcpa_pkg::ram_req_t         ram_req;
    logic [fcpa_pkg::IDX_W-1:0] ram_rdata;

    // configuration registers
    fcpa_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // free-list links: one access per cycle, read data registered
    fcpa_link_ram u_link_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // head, counter, rebuild sequencer and output register
    fcpa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

endmodule

// ----- rtl/fcpa_checker.sv -----
`include "fixed_chunk_pool_allocator_assert.svh"

module fcpa_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input fcpa_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input fcpa_pkg::out_item_t m_data
);

    // a stalled result holds still
    `FCPA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // one item in flight: no accept in the cycle after an accept
    `FCPA_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "input accepted back to back")

    // refused or rejected items carry no grant
    `FCPA_ASSERT_SAME(a_no_grant_on_error, aclk, aresetn, m_valid && m_data.status != fcpa_pkg::STATUS_OK, m_data.granted_index == '0 && m_data.granted_address == '0, "grant on failed item")

    // status uses defined codes only
    `FCPA_ASSERT_SAME(a_status_code, aclk, aresetn, m_valid, m_data.status == fcpa_pkg::STATUS_OK || m_data.status == fcpa_pkg::STATUS_REFUSED || m_data.status == fcpa_pkg::STATUS_RANGE, "undefined status code")

endmodule

bind fixed_chunk_pool_allocator fcpa_checker u_fcpa_checker (.*);

// ----- sim/tb_fixed_chunk_pool_allocator.sv -----
`timescale 1ns / 100ps

module tb_fixed_chunk_pool_allocator;

    // Register indexes on the configuration port; byte address is 4 * index.
    localparam int REG_CHUNK_BYTES   = 0;
    localparam int REG_CHUNKS_IN_USE = 1;
    localparam int REG_POOL_BASE     = 2;

    // Kind 3 is not decoded by the block; it must pass through untouched.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 1950;
    localparam int IDLE_PCT       = 6;
    // Slowest quiet gap: a full 256-entry rebuild plus receiver stalls.
    localparam int WATCHDOG_LIMIT = 4000;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the free list and keeps the outcomes still owed.
    // ------------------------------------------------------------------
    class alloc_tracker;
        bit [fcpa_pkg::BYTES_W-1:0] chunk_bytes = 16'd8;
        bit [fcpa_pkg::CNT_W-1:0]   chunks_in_use;
        bit [fcpa_pkg::ADDR_W-1:0]  pool_base;
        bit [fcpa_pkg::IDX_W-1:0]   links [fcpa_pkg::POOL_SPAN];
        bit [fcpa_pkg::IDX_W-1:0]   head;
        bit [fcpa_pkg::CNT_W-1:0]   free_cnt;
        fcpa_pkg::out_item_t        pending_outcomes [$];
        int                         requests, grants, refusals, rejects, mismatches;

        function void set_reg(int idx, logic [31:0] value);
            case (idx)
                REG_CHUNK_BYTES:   chunk_bytes   = value[fcpa_pkg::BYTES_W-1:0];
                REG_CHUNKS_IN_USE: chunks_in_use = value[fcpa_pkg::CNT_W-1:0];
                REG_POOL_BASE:     pool_base     = value;
                default: ;
            endcase
        endfunction

        function int unsigned pool_count();
            return (chunks_in_use > fcpa_pkg::POOL_SPAN) ? fcpa_pkg::POOL_SPAN
                                                         : chunks_in_use;
        endfunction

        function fcpa_pkg::out_item_t predict_outcome(fcpa_pkg::in_item_t it);
            fcpa_pkg::out_item_t res;
            int unsigned         n;
            logic [31:0]         offset;
            res        = '0;
            res.status = fcpa_pkg::STATUS_OK;
            n          = pool_count();
            case (it.kind)
                fcpa_pkg::KIND_ALLOC: begin
                    if (it.request_bytes > chunk_bytes || free_cnt == 0) begin
                        res.status = fcpa_pkg::STATUS_REFUSED;
                    end else begin
                        offset              = {24'b0, head} * {16'b0, chunk_bytes};
                        res.granted_index   = head;
                        res.granted_address = pool_base + offset;
                        head                = links[head];
                        free_cnt            = free_cnt - 1'b1;
                    end
                end
                fcpa_pkg::KIND_FREE: begin
                    if (it.chunk_index >= n || free_cnt == fcpa_pkg::COUNT_MAX) begin
                        res.status = fcpa_pkg::STATUS_RANGE;
                    end else begin
                        links[it.chunk_index] = (free_cnt != 0) ? head : '0;
                        head                  = it.chunk_index;
                        free_cnt              = free_cnt + 1'b1;
                    end
                end
                fcpa_pkg::KIND_RESET: begin
                    for (int i = 0; i < n; i++)
                        links[i] = (i == 0) ? '0 : fcpa_pkg::IDX_W'(i - 1);
                    head     = (n == 0) ? '0 : fcpa_pkg::IDX_W'(n - 1);
                    free_cnt = fcpa_pkg::CNT_W'(n);
                end
                default: ;
            endcase
            res.free_count = free_cnt;
            return res;
        endfunction

        function void note_request(fcpa_pkg::in_item_t it);
            fcpa_pkg::out_item_t res;
            res = predict_outcome(it);
            requests++;
            if (res.status == fcpa_pkg::STATUS_REFUSED) refusals++;
            else if (res.status == fcpa_pkg::STATUS_RANGE) rejects++;
            else if (it.kind == fcpa_pkg::KIND_ALLOC) grants++;
            pending_outcomes.push_back(res);
        endfunction

        function void check_outcome(fcpa_pkg::out_item_t got);
            fcpa_pkg::out_item_t want;
            if (pending_outcomes.size() == 0) begin
                $error("unexpected result item %h with nothing outstanding", got);
                mismatches++;
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (got.granted_index !== want.granted_index) begin
                $error("granted_index: expected %0d, actual %0d",
                       want.granted_index, got.granted_index);
                mismatches++;
            end
            if (got.granted_address !== want.granted_address) begin
                $error("granted_address: expected %h, actual %h",
                       want.granted_address, got.granted_address);
                mismatches++;
            end
            if (got.free_count !== want.free_count) begin
                $error("free_count: expected %0d, actual %0d",
                       want.free_count, got.free_count);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports; every input starts at a known value.
    // ------------------------------------------------------------------
    logic                         aclk    = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    fcpa_pkg::in_item_t           s_data  = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    fcpa_pkg::out_item_t          m_data;
    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [fcpa_pkg::PADDR_W-1:0] paddr   = '0;
    logic [31:0]                  pwdata  = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    alloc_tracker tracker;
    bit           idle_on = 1'b1;
    int           settings_applied;

    always #5 aclk = ~aclk;

    fixed_chunk_pool_allocator uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Stall the receiver now and then; hold ready high while idling is off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Sample both handshakes at the edge: check the result first, then log
    // the new item. A result never belongs to an item taken at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) tracker.check_outcome(m_data);
            if (s_valid && s_ready) tracker.note_request(s_data);
        end
    end

    // Abort when neither channel nor the config port moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) quiet = 0;
            else quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic fcpa_pkg::in_item_t make_item(logic [1:0] kind,
                                                     logic [fcpa_pkg::BYTES_W-1:0] req,
                                                     logic [fcpa_pkg::IDX_W-1:0] idx);
        fcpa_pkg::in_item_t it;
        it.kind          = kind;
        it.request_bytes = req;
        it.chunk_index   = idx;
        return it;
    endfunction

    // Offer one item and return at the edge that takes it. Valid stays high
    // on return so a back-to-back item needs no second assignment that step.
    task automatic send_item(input fcpa_pkg::in_item_t it);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid and wait until every owed result has come back. Step one
    // edge first so the item taken at the current edge is already logged.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_outcomes.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Register write: setup phase, then access phase until pready, then deselect.
    task automatic write_reg(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= fcpa_pkg::PADDR_W'(4 * idx);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [fcpa_pkg::BYTES_W-1:0] cb,
                                  input logic [fcpa_pkg::CNT_W-1:0]   cnt,
                                  input logic [fcpa_pkg::ADDR_W-1:0]  base);
        write_reg(REG_CHUNK_BYTES, {16'b0, cb});
        write_reg(REG_CHUNKS_IN_USE, {23'b0, cnt});
        write_reg(REG_POOL_BASE, base);
        settings_applied++;
    endtask

    // Mostly well-formed traffic: fitting requests, frees inside the pool.
    function automatic fcpa_pkg::in_item_t random_op();
        fcpa_pkg::in_item_t it;
        int unsigned        roll, n;
        n                = tracker.pool_count();
        roll             = $urandom_range(99);
        it.request_bytes = fcpa_pkg::BYTES_W'($urandom);
        it.chunk_index   = fcpa_pkg::IDX_W'($urandom);
        if (roll < 46) begin
            it.kind = fcpa_pkg::KIND_ALLOC;
            roll    = $urandom_range(99);
            if (roll < 70)
                it.request_bytes = fcpa_pkg::BYTES_W'($urandom_range(tracker.chunk_bytes, 0));
            else if (roll < 85)
                it.request_bytes = tracker.chunk_bytes
                                   + fcpa_pkg::BYTES_W'($urandom_range(1));
        end else if (roll < 90) begin
            it.kind = fcpa_pkg::KIND_FREE;
            if (n != 0 && $urandom_range(9) != 0)
                it.chunk_index = fcpa_pkg::IDX_W'($urandom_range(n - 1));
        end else if (roll < 97) begin
            it.kind = fcpa_pkg::KIND_RESET;
        end else begin
            it.kind = KIND_UNUSED;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int                           phase;
        logic [fcpa_pkg::BYTES_W-1:0] cb;
        logic [fcpa_pkg::CNT_W-1:0]   cnt;
        logic [fcpa_pkg::ADDR_W-1:0]  base;
        fcpa_pkg::in_item_t           it;

        tracker = new();
        phase   = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: empty list, no pool, chunk size 8.
        send_item(make_item(fcpa_pkg::KIND_ALLOC, 16'd8, 8'd0));
        send_item(make_item(fcpa_pkg::KIND_FREE, 16'd0, 8'd0));
        send_item(make_item(KIND_UNUSED, 16'hFFFF, 8'hFF));
        send_item(make_item(fcpa_pkg::KIND_RESET, 16'd0, 8'd0));
        wait_idle();

        // Largest chunk and full pool; base near the top so addresses wrap.
        apply_settings(16'hFFFF, 9'd256, 32'hFFFF_FFF0);
        send_item(make_item(fcpa_pkg::KIND_RESET, 16'hFFFF, 8'hFF));
        send_item(make_item(fcpa_pkg::KIND_ALLOC, 16'd0, 8'd0));
        send_item(make_item(fcpa_pkg::KIND_ALLOC, 16'hFFFF, 8'hFF));
        send_item(make_item(fcpa_pkg::KIND_FREE, 16'd0, 8'hFF));
        send_item(make_item(fcpa_pkg::KIND_FREE, 16'hFFFF, 8'd0));
        send_item(make_item(fcpa_pkg::KIND_FREE, 16'd0, 8'd0));       // same chunk twice
        send_item(make_item(fcpa_pkg::KIND_ALLOC, 16'd1, 8'd0));
        send_item(make_item(fcpa_pkg::KIND_ALLOC, 16'd1, 8'd0));
        send_item(make_item(KIND_UNUSED, 16'h5A5A, 8'hA5));
        wait_idle();

        // Zero chunk size lets only zero-byte requests through; count
        // beyond the depth clamps the pool to 256.
        apply_settings(16'd0, 9'd511, 32'h1234_5678);
        send_item(make_item(fcpa_pkg::KIND_ALLOC, 16'd0, 8'd0));
        send_item(make_item(fcpa_pkg::KIND_ALLOC, 16'd1, 8'd0));
        send_item(make_item(fcpa_pkg::KIND_RESET, 16'd0, 8'd0));
        send_item(make_item(fcpa_pkg::KIND_FREE, 16'd0, 8'hFF));
        wait_idle();

        // Single-chunk pool: drain it, refuse, free out of range and back in.
        apply_settings(16'd1, 9'd1, 32'hFFFF_FFFF);
        send_item(make_item(fcpa_pkg::KIND_RESET, 16'd0, 8'd0));
        send_item(make_item(fcpa_pkg::KIND_ALLOC, 16'd1, 8'd0));
        send_item(make_item(fcpa_pkg::KIND_ALLOC, 16'd0, 8'd0));
        send_item(make_item(fcpa_pkg::KIND_FREE, 16'd0, 8'd1));
        send_item(make_item(fcpa_pkg::KIND_FREE, 16'd0, 8'd0));
        send_item(make_item(fcpa_pkg::KIND_FREE, 16'd0, 8'hFF));
        send_item(make_item(fcpa_pkg::KIND_ALLOC, 16'd2, 8'd0));
        send_item(make_item(fcpa_pkg::KIND_ALLOC, 16'd1, 8'd0));

        // Random phases, each under a fresh setting.
        while (tracker.requests < RANDOM_ITEMS + 25) begin
            wait_idle();
            case ($urandom_range(4))
                0:       cb = 16'd0;
                1:       cb = 16'd1;
                2:       cb = 16'hFFFF;
                default: cb = fcpa_pkg::BYTES_W'($urandom_range(300, 1));
            endcase
            case ($urandom_range(6))
                0:       cnt = 9'd0;
                1:       cnt = 9'd1;
                2:       cnt = 9'd256;
                3:       cnt = 9'd511;
                default: cnt = fcpa_pkg::CNT_W'($urandom_range(40, 2));
            endcase
            case ($urandom_range(3))
                0:       base = 32'd0;
                1:       base = 32'hFFFF_FFFF;
                default: base = $urandom;
            endcase

            if (phase == 4) begin
                // Flood a small pool with frees until the counter saturates,
                // then pop the repeated entries back off.
                apply_settings(cb, 9'd3, base);
                send_item(make_item(fcpa_pkg::KIND_RESET, 16'd0, 8'd0));
                repeat (545) begin
                    it = random_op();
                    it.kind = fcpa_pkg::KIND_FREE;
                    if ($urandom_range(19) != 0)
                        it.chunk_index = fcpa_pkg::IDX_W'($urandom_range(2));
                    send_item(it);
                end
                repeat (60) begin
                    it = random_op();
                    it.kind = fcpa_pkg::KIND_ALLOC;
                    send_item(it);
                end
            end else begin
                apply_settings(cb, cnt, base);
                // Keep two phases free of any idling on either side.
                idle_on = !(phase == 2 || phase == 3);
                send_item(make_item(fcpa_pkg::KIND_RESET, fcpa_pkg::BYTES_W'($urandom),
                                    fcpa_pkg::IDX_W'($urandom)));
                repeat (110) send_item(random_op());
                idle_on = 1'b1;
            end
            phase++;
        end

        wait_idle();
        repeat (8) @(posedge aclk);

        $display("Summary: %0d items over %0d register settings, including a saturated counter",
                 tracker.requests, settings_applied);
        $display("Summary: %0d grants, %0d refused allocations, %0d rejected frees",
                 tracker.grants, tracker.refusals, tracker.rejects);
        if (tracker.mismatches == 0 && tracker.pending_outcomes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
